### src/expression_lexer_assert.svh
// Assertion macros used by the expression lexer top level.
`ifndef EXPRESSION_LEXER_ASSERT_SVH
`define EXPRESSION_LEXER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define EXLEX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("expression_lexer assertion failed");
// Next-cycle implication, disabled during reset.
`define EXLEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("expression_lexer assertion failed");
`else
`define EXLEX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EXLEX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/exlex_pkg.sv
// Shared types, constants and helpers of the expression lexer.
`default_nettype none
package exlex_pkg;

	localparam longint unsigned MAX_SOURCE_BYTES_DEF = 64'd65536;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam int unsigned POS_W = 16;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [3:0] {
		TK_NUMBER = 4'd0,
		TK_IDENT  = 4'd1,
		TK_LET    = 4'd2,
		TK_NULL   = 4'd3,
		TK_EQUALS = 4'd4,
		TK_OPEN   = 4'd5,
		TK_CLOSE  = 4'd6,
		TK_OPER   = 4'd7,
		TK_END    = 4'd8,
		TK_ERROR  = 4'd9
	} tok_kind_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef struct packed {
		tok_kind_t        kind;
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] length;
		logic             last;
	} token_t;

	// One queue entry: the tokens caused by one input transfer.
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Letters of the keyword "let", by index.
	function automatic logic [7:0] let_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = 8'h6C;
			2'd1:    ch = 8'h65;
			2'd2:    ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Letters of the keyword "null", by index.
	function automatic logic [7:0] null_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = 8'h6E;
			2'd1:    ch = 8'h75;
			default: ch = 8'h6C;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

### src/exlex_front.sv
// Front end: classifies source bytes, tracks the open token, builds token entries.
`default_nettype none
module exlex_front import exlex_pkg::*; #(
	parameter longint unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       operation,
	input  wire logic [7:0] char_in,
	output logic            push,
	output entry_t          push_entry
);

	localparam logic [POS_W-1:0] POS_CAP = (MAX_SOURCE_BYTES - 64'd1 > 64'hFFFF) ?
		{POS_W{1'b1}} : POS_W'(MAX_SOURCE_BYTES - 64'd1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_HALT
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] start_q, start_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             let_q, let_d;
	logic             null_q, null_d;

	logic is_dig, is_alp, is_ws, is_op;
	logic have_close, have_own;
	token_t close_tok, own_tok;
	tok_kind_t close_kind;
	logic [LEN_W-1:0] len_inc;
	logic [POS_W-1:0] pos_inc;

	// Classify the incoming byte
	always_comb begin
		is_dig = (char_in >= 8'h30) && (char_in <= 8'h39);
		is_alp = ((char_in >= 8'h61) && (char_in <= 8'h7A)) ||
			((char_in >= 8'h41) && (char_in <= 8'h5A));
		is_ws  = (char_in == CH_SPACE) || (char_in == CH_NL) || (char_in == CH_TAB);
		is_op  = (char_in == CH_PLUS) || (char_in == CH_MINUS) || (char_in == CH_STAR) ||
			(char_in == CH_SLASH) || (char_in == CH_PCT);
	end

	// Closed token of the open run, keywords resolved
	always_comb begin
		if (mode_q == MODE_NUM) begin
			close_kind = TK_NUMBER;
		end else if (let_q && (len_q == LEN_W'(3))) begin
			close_kind = TK_LET;
		end else if (null_q && (len_q == LEN_W'(4))) begin
			close_kind = TK_NULL;
		end else begin
			close_kind = TK_IDENT;
		end
		close_tok = '{kind: close_kind, start: start_q, length: len_q, last: 1'b0};
		len_inc = (len_q == {LEN_W{1'b1}}) ? len_q : len_q + LEN_W'(1);
		pos_inc = (pos_q < POS_CAP) ? pos_q + POS_W'(1) : pos_q;
	end

	// Next state and tokens of one transfer
	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_q;
		start_d    = start_q;
		len_d      = len_q;
		let_d      = let_q;
		null_d     = null_q;
		have_close = 1'b0;
		have_own   = 1'b0;
		own_tok    = '{kind: TK_OPER, start: pos_q, length: LEN_W'(1), last: 1'b0};
		if (take) begin
			if (operation == OP_EOS) begin
				if (mode_q != MODE_HALT) begin
					have_close = (mode_q == MODE_NUM) || (mode_q == MODE_IDENT);
					have_own   = 1'b1;
					own_tok    = '{kind: TK_END, start: pos_q, length: '0, last: 1'b1};
				end
				mode_d  = MODE_IDLE;
				pos_d   = '0;
				start_d = '0;
				len_d   = '0;
				let_d   = 1'b1;
				null_d  = 1'b1;
			end else if (mode_q != MODE_HALT) begin
				if (((mode_q == MODE_NUM) && is_dig) || ((mode_q == MODE_IDENT) && is_alp)) begin
					// extend the open run
					let_d  = let_q && (len_q < LEN_W'(3)) && (char_in == let_char(len_q[1:0]));
					null_d = null_q && (len_q < LEN_W'(4)) && (char_in == null_char(len_q[1:0]));
					len_d  = len_inc;
				end else begin
					have_close = (mode_q == MODE_NUM) || (mode_q == MODE_IDENT);
					mode_d     = MODE_IDLE;
					if (char_in == CH_LPAREN) begin
						have_own     = 1'b1;
						own_tok.kind = TK_OPEN;
					end else if (char_in == CH_RPAREN) begin
						have_own     = 1'b1;
						own_tok.kind = TK_CLOSE;
					end else if (is_op) begin
						have_own     = 1'b1;
						own_tok.kind = TK_OPER;
					end else if (char_in == CH_EQ) begin
						have_own     = 1'b1;
						own_tok.kind = TK_EQUALS;
					end else if (is_dig || is_alp) begin
						// open a new run
						mode_d  = is_dig ? MODE_NUM : MODE_IDENT;
						start_d = pos_q;
						len_d   = LEN_W'(1);
						let_d   = (char_in == let_char(2'd0));
						null_d  = (char_in == null_char(2'd0));
					end else if (!is_ws) begin
						have_own     = 1'b1;
						own_tok.kind = TK_ERROR;
						own_tok.last = 1'b1;
						mode_d       = MODE_HALT;
					end
				end
				pos_d = pos_inc;
			end
		end
		push            = have_close || have_own;
		push_entry.two  = have_close && have_own;
		push_entry.tok0 = have_close ? close_tok : own_tok;
		push_entry.tok1 = own_tok;
	end

	// Hold scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			let_q   <= 1'b1;
			null_q  <= 1'b1;
		end else begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			let_q   <= let_d;
			null_q  <= null_d;
		end
	end

endmodule
`default_nettype wire

### src/exlex_queue.sv
// Short queue of token entries between front and back end.
`default_nettype none
module exlex_queue import exlex_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      pop_entry,
	output q_stat_t     stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_entry  = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

### src/exlex_back.sv
// Back end: unpacks queued entries and drives the token output register.
`default_nettype none
module exlex_back import exlex_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t stat,
	input  wire entry_t  pop_entry,
	output logic         pop,
	input  wire logic    out_ready,
	output logic         out_valid,
	output token_t       out_tok
);

	logic   valid_q;
	logic   pend_q;
	token_t pend_tok_q;
	token_t tok_q;
	logic   load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !pend_q && !stat.empty;
	assign out_valid = valid_q;
	assign out_tok   = tok_q;

	// Advance output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!stat.empty) begin
				valid_q <= 1'b1;
				pend_q  <= pop_entry.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load token payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				tok_q <= pend_tok_q;
			end else if (!stat.empty) begin
				tok_q      <= pop_entry.tok0;
				pend_tok_q <= pop_entry.tok1;
			end
		end
	end

endmodule
`default_nettype wire

### src/expression_lexer.sv
// Expression lexer: one source byte per transfer in, tokens out.
// The first token of a byte is written to the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that closes a run
// and emits its own token yields two tokens, sent in turn through the single output register.
// Reset: arst_n clears scanner state, queue and output; position restarts at zero.
`default_nettype none
`include "expression_lexer_assert.svh"
module expression_lexer import exlex_pkg::*; #(
	parameter longint unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF,
	parameter int unsigned     QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] char_in
	input  wire logic                   s_axis_tuser,  // [0] operation
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [3:0] token_kind, [19:4] token_start, [35:20] token_length, [39:36] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tlast
);

	logic    take;
	logic    push;
	entry_t  push_entry;
	logic    pop;
	entry_t  pop_entry;
	q_stat_t stat;
	token_t  out_tok;

	assign s_axis_tready = !stat.full;
	assign take          = s_axis_tvalid && s_axis_tready;

	exlex_front #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.operation  (s_axis_tuser),
		.char_in    (s_axis_tdata),
		.push       (push),
		.push_entry (push_entry)
	);

	exlex_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (stat)
	);

	exlex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_tok   (out_tok)
	);

	// Pack the output transfer
	assign m_axis_tdata = {4'b0000, out_tok.length, out_tok.start, out_tok.kind};
	assign m_axis_tlast = out_tok.last;

	`EXLEX_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !stat.full)
	`EXLEX_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !stat.empty)
	`EXLEX_ASSERT_IMPL(a_last_kind, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		((out_tok.kind == TK_END) && (out_tok.length == '0)) || ((out_tok.kind == TK_ERROR) && (out_tok.length == LEN_W'(1))))

endmodule
`default_nettype wire
